[sv/json_string_unescape_defines.svh]
// ----------------------------------------------------------------------------
// json_string_unescape_defines.svh
// Assertion macros shared by the string unescape RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define JSU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jsu assertion failed");

// Next-cycle implication, sampled on clk, off while reset is asserted
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jsu assertion failed");

`endif

[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helpers for the JSON string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// decode modes
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESC   = 2'd1;
	localparam logic [1:0] MODE_HEX   = 2'd2;

	// error codes
	localparam logic [2:0] ERR_CTRL    = 3'd0;
	localparam logic [2:0] ERR_ESC     = 3'd1;
	localparam logic [2:0] ERR_HEX     = 3'd2;
	localparam logic [2:0] ERR_SHORT   = 3'd3;
	localparam logic [2:0] ERR_UNF_ESC = 3'd4;
	localparam logic [2:0] ERR_UNF_STR = 3'd5;

	// characters
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	// UTF-8 encoding
	localparam logic [15:0] CP_1BYTE_MAX = 16'h007F;
	localparam logic [15:0] CP_2BYTE_MAX = 16'h07FF;
	localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
	localparam logic [7:0]  UTF8_CONT    = 8'h80;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] err;
	} res_t;

	// all results caused by one input item, res[0] goes out first
	typedef struct packed {
		logic [1:0]       last_idx;
		res_t [3:0]       res;
	} desc_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic head_valid;
	} qstat_t;

	// hex digit: {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				r = {1'b1, c[3:0]};
			end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
				r = {1'b1, c[3:0] + 4'd9};
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts text bytes, tracks escape state and builds the result list per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [7:0]     s_tdata,
	input  wire logic           s_tlast,
	input  wire jsu_pkg::qstat_t qstat,
	output logic                push,
	output jsu_pkg::desc_t      push_desc
);
	import jsu_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] acc_q, acc_d;
	logic        bad_q, bad_d;

	logic [2:0]  n_res;
	logic        data_done;
	logic        clr;
	logic [4:0]  hv;
	logic [15:0] cp;
	logic        bad_n;
	logic [7:0]  esc_val;
	logic        esc_ok;
	desc_t       desc;

	assign s_tready = !qstat.full;
	assign hv       = hex_digit(s_tdata);
	assign bad_n    = bad_q | !hv[4];
	assign cp       = {acc_q[11:0], (hv[4] ? hv[3:0] : 4'd0)};

	// simple escape letters
	always_comb begin
		esc_ok  = 1'b1;
		esc_val = s_tdata;
		unique case (s_tdata)
			CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = s_tdata;
			CH_B: esc_val = 8'h08;
			CH_F: esc_val = 8'h0C;
			CH_N: esc_val = 8'h0A;
			CH_R: esc_val = 8'h0D;
			CH_T: esc_val = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	// per-byte decode
	always_comb begin
		desc      = '0;
		n_res     = 3'd0;
		data_done = 1'b0;
		clr       = 1'b0;
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		bad_d     = bad_q;

		if (mode_q == MODE_ESC) begin
			if (esc_ok) begin
				desc.res[0] = '{kind: KIND_DATA, data: esc_val, err: '0};
				n_res       = 3'd1;
				mode_d      = MODE_PLAIN;
				data_done   = 1'b1;
			end else if (s_tdata == CH_U) begin
				mode_d = MODE_HEX;
				cnt_d  = 2'd0;
				acc_d  = 16'd0;
				bad_d  = 1'b0;
				if (s_tlast) begin
					desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_SHORT};
					n_res       = 3'd1;
					clr         = 1'b1;
				end
			end else begin
				desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_ESC};
				n_res       = 3'd1;
				clr         = 1'b1;
			end
		end else if (mode_q == MODE_HEX) begin
			bad_d = bad_n;
			acc_d = cp;
			if (cnt_q == 2'd3) begin
				clr = 1'b1;
				if (bad_n) begin
					desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_HEX};
					n_res       = 3'd1;
				end else begin
					data_done = 1'b1;
					if (cp <= CP_1BYTE_MAX) begin
						desc.res[0] = '{kind: KIND_DATA, data: cp[7:0], err: '0};
						n_res       = 3'd1;
					end else if (cp <= CP_2BYTE_MAX) begin
						desc.res[0] = '{kind: KIND_DATA, data: UTF8_LEAD2 | {3'd0, cp[10:6]},
							err: '0};
						desc.res[1] = '{kind: KIND_DATA, data: UTF8_CONT | {2'd0, cp[5:0]},
							err: '0};
						n_res       = 3'd2;
					end else begin
						desc.res[0] = '{kind: KIND_DATA, data: UTF8_LEAD3 | {4'd0, cp[15:12]},
							err: '0};
						desc.res[1] = '{kind: KIND_DATA, data: UTF8_CONT | {2'd0, cp[11:6]},
							err: '0};
						desc.res[2] = '{kind: KIND_DATA, data: UTF8_CONT | {2'd0, cp[5:0]},
							err: '0};
						n_res       = 3'd3;
					end
				end
			end else begin
				cnt_d = cnt_q + 2'd1;
				if (s_tlast) begin
					desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_SHORT};
					n_res       = 3'd1;
					clr         = 1'b1;
				end
			end
		end else begin
			// plain body, unused mode code behaves the same
			mode_d = MODE_PLAIN;
			if (s_tdata == CH_QUOTE) begin
				desc.res[0] = '{kind: KIND_CLOSE, data: '0, err: '0};
				n_res       = 3'd1;
				clr         = 1'b1;
			end else if (s_tdata < CTRL_LIMIT) begin
				desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_CTRL};
				n_res       = 3'd1;
				clr         = 1'b1;
			end else if (s_tdata == CH_BSLASH) begin
				if (s_tlast) begin
					desc.res[0] = '{kind: KIND_ERROR, data: '0, err: ERR_UNF_ESC};
					n_res       = 3'd1;
					clr         = 1'b1;
				end else begin
					mode_d = MODE_ESC;
				end
			end else begin
				desc.res[0] = '{kind: KIND_DATA, data: s_tdata, err: '0};
				n_res       = 3'd1;
				data_done   = 1'b1;
			end
		end

		// text ended right after decoded data
		if (data_done && s_tlast) begin
			desc.res[n_res[1:0]] = '{kind: KIND_ERROR, data: '0, err: ERR_UNF_STR};
			n_res                = n_res + 3'd1;
			clr                  = 1'b1;
		end

		if (clr) begin
			mode_d = MODE_PLAIN;
			cnt_d  = 2'd0;
			acc_d  = 16'd0;
			bad_d  = 1'b0;
		end

		desc.last_idx = n_res[1:0] - 2'd1;
	end

	assign push      = s_tvalid && s_tready && (n_res != 3'd0);
	assign push_desc = desc;

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cnt_q  <= 2'd0;
			acc_q  <= 16'd0;
			bad_q  <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			bad_q  <= bad_d;
		end
	end

endmodule

`default_nettype wire

[sv/jsu_fifo.sv]
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of result lists between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jsu_pkg::desc_t push_desc,
	input  wire logic           pop,
	output jsu_pkg::qstat_t     qstat,
	output jsu_pkg::desc_t      head_desc
);
	import jsu_pkg::*;

	desc_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_push;
	logic           do_pop;

	assign qstat.full       = (count_q == (QAW+1)'(QDEPTH));
	assign qstat.head_valid = (count_q != '0);
	assign head_desc        = mem_q[rd_ptr_q];
	assign do_push          = push && !qstat.full;
	assign do_pop           = pop && qstat.head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Walks queued result lists; drives one result item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jsu_pkg::qstat_t qstat,
	input  wire jsu_pkg::desc_t  head_desc,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [15:0]          m_tdata,
	output logic                 m_tlast,
	output logic [1:0]           m_tuser
);
	import jsu_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [2:0] err_q;
	logic       last_q;
	logic       advance;
	logic       at_end;
	res_t       sel;

	assign advance = qstat.head_valid && (!valid_q || m_tready);
	assign sel     = head_desc.res[idx_q];
	assign at_end  = (idx_q == head_desc.last_idx);
	assign pop     = advance && at_end;

	// list position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= sel.kind;
			data_q <= sel.data;
			err_q  <= sel.err;
			last_q <= at_end;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {5'd0, err_q, data_q};

endmodule

`default_nettype wire

[sv/json_string_unescape.sv]
// JSON string unescape. Takes the bytes of a string body (after the opening
// quote) one item per cycle on the s_ side while s_tready is high and gives
// decoded items on the m_ side: data bytes, a close marker on the unescaped
// quote, or an error code. The front end accepts a new byte every cycle as
// long as the four-entry queue has room; the back end sends one result per
// cycle while m_tready is high, so a byte that yields n results (up to four:
// three UTF-8 bytes of a \u escape plus an end-of-text error) goes out as n
// items. An accepted byte passes the queue, then the output register. The
// output register reloads in the cycle its item is taken, so plain text flows
// at one item per cycle in and out while m_tready stays high.
// ----------------------------------------------------------------------------
// json_string_unescape
// Top level: front decoder, result queue and output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_defines.svh"

module json_string_unescape (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
	input  wire logic        s_tlast,   // text_last
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] decoded_byte, [10:8] error_code, rest 0
	output logic             m_tlast,   // run_last
	output logic [1:0]       m_tuser    // [1:0] result_kind
);
	import jsu_pkg::*;

	qstat_t qstat;
	desc_t  push_desc;
	desc_t  head_desc;
	logic   push;
	logic   pop;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_desc (push_desc)
	);

	jsu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.qstat     (qstat),
		.head_desc (head_desc)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_desc (head_desc),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// checks
	`JSU_ASSERT_IMPL(a_push_room, push, !qstat.full)
	`JSU_ASSERT_IMPL(a_close_alone, m_tvalid && (m_tuser == KIND_CLOSE), m_tlast)
	`JSU_ASSERT_IMPL(a_error_ends, m_tvalid && (m_tuser == KIND_ERROR), m_tlast)
	`JSU_ASSERT_NEXT(a_pop_frees, pop && !push, !qstat.full)

endmodule

`default_nettype wire
